// File: sv/decimal_digit_counting_sort_assert.svh
// assertion macros for the decimal digit counting sort block
// included by the modules that carry concurrent checks, no other dependencies
`ifndef DECIMAL_DIGIT_COUNTING_SORT_ASSERT_SVH
`define DECIMAL_DIGIT_COUNTING_SORT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DDCS_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ddcs check failed");
`define DDCS_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ddcs check failed");
`else
`define DDCS_ASSERT_RST(label, clk, rst, prop)
`define DDCS_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: sv/ddcs_pkg.sv
// shared constants and types of the decimal digit counting sort block
// no dependencies; imported by the interfaces and every module
package ddcs_pkg;

   localparam int DIGIT_COUNT     = 10;
   localparam int TOP_DIGIT       = 9;
   localparam int DIGIT_BITS      = 4;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int NUMBER_BITS_DEF = 32;
   localparam int FIFO_DEPTH      = 2;

   typedef enum logic [1:0] {
      OP_ADD_SMALL,
      OP_ADD_WIDE,
      OP_PULL
   } op_type;

   localparam int OP_BITS = $bits(op_type);

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CONVERT,
      BK_COUNT
   } back_state_type;

endpackage

// File: sv/ddcs_req_if.sv
// request channel: command and number, valid/ready handshake
// depends on ddcs_pkg
interface ddcs_req_if import ddcs_pkg::*; #(
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [NUMBER_BITS-1:0] number_value;

   modport source (output valid, output cmd, output number_value, input ready);
   modport sink   (input valid, input cmd, input number_value, output ready);
endinterface

// File: sv/ddcs_rsp_if.sv
// response channel: pulled digit and its valid flag, valid/ready handshake
// depends on ddcs_pkg
interface ddcs_rsp_if import ddcs_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [DIGIT_BITS-1:0] digit;
   logic                  digit_valid;

   modport source (output valid, output digit, output digit_valid, input ready);
   modport sink   (input valid, input digit, input digit_valid, output ready);
endinterface

// File: sv/ddcs_front.sv
// front stage: takes request beats, classifies them and registers them for the queue
// depends on ddcs_pkg and ddcs_req_if
module ddcs_front import ddcs_pkg::*; #(
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   ddcs_req_if.sink               req_if,
   output logic                   push_valid,
   input  logic                   push_ready,
   output op_type                 push_op,
   output logic [NUMBER_BITS-1:0] push_number
);

   logic                   valid_ff;
   logic                   valid_in;
   op_type                 op_ff;
   op_type                 op_in;
   logic [NUMBER_BITS-1:0] number_ff;
   logic                   accept;

   assign req_if.ready = !valid_ff || push_ready;
   assign accept       = req_if.valid && req_if.ready;
   assign valid_in     = accept || (valid_ff && !push_ready);

   // single digit numbers skip the converter
   always_comb begin
      priority if (req_if.cmd) begin
         op_in = OP_PULL;
      end else if (req_if.number_value < NUMBER_BITS'(DIGIT_COUNT)) begin
         op_in = OP_ADD_SMALL;
      end else begin
         op_in = OP_ADD_WIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= op_in;
         number_ff <= req_if.number_value;
      end
   end

   assign push_valid  = valid_ff;
   assign push_op     = op_ff;
   assign push_number = number_ff;

endmodule

// File: sv/ddcs_fifo.sv
// short queue between the front and back stages
// depends on ddcs_pkg for the default depth
module ddcs_fifo import ddcs_pkg::*; #(
   parameter int WIDTH = OP_BITS + NUMBER_BITS_DEF,
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                push;
   logic                pop;

   assign push_ready = count_ff != CNT_BITS'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/ddcs_back.sv
// back stage: binary to decimal converter, ten saturating digit counters, response register
// depends on ddcs_pkg, ddcs_rsp_if and the assertion macro header
`include "decimal_digit_counting_sort_assert.svh"

module ddcs_back import ddcs_pkg::*; #(
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  op_type                 pop_op,
   input  logic [NUMBER_BITS-1:0] pop_number,
   ddcs_rsp_if.source             rsp_if
);

   localparam int BCD_DIGITS  = (NUMBER_BITS * 30103) / 100000 + 1;
   localparam int BCD_W       = BCD_DIGITS * DIGIT_BITS;
   localparam int STEP_CYCLES = (NUMBER_BITS + 3) / 4;
   localparam int PAD_BITS    = STEP_CYCLES * 4;
   localparam int STEP_BITS   = $clog2(STEP_CYCLES + 1);
   localparam int HIT_BITS    = $clog2(BCD_DIGITS + 1);
   localparam int SUM_BITS    = COUNT_BITS + HIT_BITS;

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [STEP_BITS-1:0]  step_ff;
   logic [STEP_BITS-1:0]  step_in;
   logic [PAD_BITS-1:0]   bin_ff;
   logic [PAD_BITS-1:0]   bin_in;
   logic [BCD_W-1:0]      bcd_ff;
   logic [BCD_W-1:0]      bcd_in;
   logic [COUNT_BITS-1:0] count_ff [DIGIT_COUNT];
   logic [COUNT_BITS-1:0] count_in [DIGIT_COUNT];
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DIGIT_BITS-1:0] rsp_digit_ff;
   logic [DIGIT_BITS-1:0] rsp_digit_in;
   logic                  rsp_dv_ff;
   logic                  rsp_dv_in;

   logic                  rsp_free;
   logic                  any_nonzero;
   logic [DIGIT_BITS-1:0] sel_digit;
   logic [COUNT_BITS-1:0] sel_count;
   logic [PAD_BITS-1:0]   bin_step;
   logic [BCD_W-1:0]      bcd_step;
   logic [HIT_BITS-1:0]   hits [DIGIT_COUNT];
   logic                  pull_fire;

   function automatic logic [COUNT_BITS-1:0] sat_add(
      input logic [COUNT_BITS-1:0] c,
      input logic [HIT_BITS-1:0]   k
   );
      logic [SUM_BITS-1:0] sum;
      sum = SUM_BITS'(c) + SUM_BITS'(k);
      if (sum > SUM_BITS'({COUNT_BITS{1'b1}})) begin
         return {COUNT_BITS{1'b1}};
      end
      return sum[COUNT_BITS-1:0];
   endfunction

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   // highest digit with a nonempty counter
   always_comb begin
      any_nonzero = 1'b0;
      sel_digit   = '0;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (count_ff[d] != '0) begin
            any_nonzero = 1'b1;
            sel_digit   = DIGIT_BITS'(d);
         end
      end
      sel_count = count_ff[sel_digit];
   end

   // four shift-and-add-3 steps per cycle
   always_comb begin
      logic [BCD_W-1:0]    bcd_v;
      logic [PAD_BITS-1:0] bin_v;
      bcd_v = bcd_ff;
      bin_v = bin_ff;
      for (int s = 0; s < 4; s++) begin
         for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_v[i*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
               bcd_v[i*DIGIT_BITS +: DIGIT_BITS] =
                  bcd_v[i*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
            end
         end
         bcd_v = {bcd_v[BCD_W-2:0], bin_v[PAD_BITS-1]};
         bin_v = {bin_v[PAD_BITS-2:0], 1'b0};
      end
      bcd_step = bcd_v;
      bin_step = bin_v;
   end

   // per digit occurrence counts, leading zeros dropped
   always_comb begin
      logic                  above;
      logic [BCD_DIGITS-1:0] keep;
      above = 1'b0;
      for (int i = BCD_DIGITS - 1; i >= 0; i--) begin
         above   = above || (bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] != '0);
         keep[i] = above || (i == 0);
      end
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         hits[d] = '0;
         for (int i = 0; i < BCD_DIGITS; i++) begin
            if (keep[i] && bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] == DIGIT_BITS'(d)) begin
               hits[d] = hits[d] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      pop_ready    = 1'b0;
      pull_fire    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_digit_in = rsp_digit_ff;
      rsp_dv_in    = rsp_dv_ff;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         count_in[d] = count_ff[d];
      end
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               unique case (pop_op)
                  OP_PULL: begin
                     if (rsp_free) begin
                        pop_ready    = 1'b1;
                        pull_fire    = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_dv_in    = any_nonzero;
                        rsp_digit_in = any_nonzero ? sel_digit : '0;
                        if (any_nonzero) begin
                           count_in[sel_digit] = sel_count - 1'b1;
                        end
                     end
                  end
                  OP_ADD_SMALL: begin
                     pop_ready = 1'b1;
                     count_in[pop_number[DIGIT_BITS-1:0]] =
                        sat_add(count_ff[pop_number[DIGIT_BITS-1:0]], HIT_BITS'(1));
                  end
                  OP_ADD_WIDE: begin
                     pop_ready = 1'b1;
                     bin_in    = PAD_BITS'(pop_number);
                     bcd_in    = '0;
                     step_in   = '0;
                     state_in  = BK_CONVERT;
                  end
                  default: begin
                     pop_ready = 1'b1;
                  end
               endcase
            end
         end
         BK_CONVERT: begin
            bcd_in  = bcd_step;
            bin_in  = bin_step;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(STEP_CYCLES - 1)) begin
               state_in = BK_COUNT;
            end
         end
         BK_COUNT: begin
            for (int d = 0; d < DIGIT_COUNT; d++) begin
               count_in[d] = sat_add(count_ff[d], hits[d]);
            end
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < DIGIT_COUNT; d++) begin
            count_ff[d] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int d = 0; d < DIGIT_COUNT; d++) begin
            count_ff[d] <= count_in[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_dv_ff    <= rsp_dv_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.digit       = rsp_digit_ff;
   assign rsp_if.digit_valid = rsp_dv_ff;

   `DDCS_ASSERT_NR(a_reset_idle, clock, reset |=> (state_ff == BK_IDLE && !rsp_valid_ff))
   `DDCS_ASSERT_RST(a_empty_pull, clock, reset, (pull_fire && !any_nonzero) |=> (rsp_valid_ff && !rsp_dv_ff && rsp_digit_ff == '0))
   `DDCS_ASSERT_RST(a_pull_dec, clock, reset, (pull_fire && any_nonzero) |=> (rsp_dv_ff && count_ff[rsp_digit_ff] == $past(sel_count) - 1'b1))
   `DDCS_ASSERT_RST(a_pop_idle, clock, reset, pop_ready |-> (state_ff == BK_IDLE && pop_valid))

endmodule

// File: sv/decimal_digit_counting_sort.sv
// top level of the decimal digit counting sort block
// depends on ddcs_pkg, ddcs_req_if, ddcs_rsp_if, ddcs_front, ddcs_fifo and ddcs_back
//
// req_if carries commands: cmd low adds the decimal digits of number_value to ten
// saturating counters (a number below ten counts as one digit), cmd high pulls the
// largest counted digit and decrements its counter. Adds give no response beat; every
// pull gives exactly one rsp_if beat, with digit_valid low and digit zero when all
// counters are empty. Beats are taken in order.
// A request passes a front register and a two entry queue before the back stage, and a
// pull answers from the response register. Pulls and adds of a number below ten are
// handled directly in the idle state. Other adds pass through the binary to decimal
// converter, which shifts four bits a cycle, then a count state that adds each digit's
// occurrences to the counters. A stalled rsp_if holds its beat in the response register;
// the back stage keeps working on adds until a pull reaches it, and the queue and front
// register keep taking requests until full. Synchronous reset clears all counters and
// empties the queue.
module decimal_digit_counting_sort import ddcs_pkg::*; #(
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ddcs_req_if.sink    req_if,
   ddcs_rsp_if.source  rsp_if
);

   localparam int ENTRY_BITS = OP_BITS + NUMBER_BITS;

   logic                   push_valid;
   logic                   push_ready;
   op_type                 push_op;
   logic [NUMBER_BITS-1:0] push_number;
   logic [ENTRY_BITS-1:0]  push_data;
   logic                   pop_valid;
   logic                   pop_ready;
   logic [ENTRY_BITS-1:0]  pop_data;
   op_type                 pop_op;
   logic [NUMBER_BITS-1:0] pop_number;

   ddcs_front #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_op     (push_op),
      .push_number (push_number)
   );

   assign push_data = {push_op, push_number};

   ddcs_fifo #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_op     = op_type'(pop_data[ENTRY_BITS-1:NUMBER_BITS]);
   assign pop_number = pop_data[NUMBER_BITS-1:0];

   ddcs_back #(
      .COUNT_BITS  (COUNT_BITS),
      .NUMBER_BITS (NUMBER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op),
      .pop_number (pop_number),
      .rsp_if     (rsp_if)
   );

endmodule
